@@ sv/dnsrp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dnsrp_pkg;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_NAME,
    PH_LABEL,
    PH_PTR,
    PH_QFIX,
    PH_RFIX,
    PH_DATA
  } phase_t;

  localparam logic [1:0] KIND_HEADER   = 2'd0;
  localparam logic [1:0] KIND_QUESTION = 2'd1;
  localparam logic [1:0] KIND_RECORD   = 2'd2;
  localparam logic [1:0] KIND_TRUNC    = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_ID     = 2'd1;
  localparam logic [1:0] ST_NOT_ANSWER = 2'd2;

  localparam logic [15:0] ID_RESET   = 16'd42;
  localparam logic [7:0]  FLAG_MASK  = 8'h80;
  localparam logic [7:0]  PTR_MASK   = 8'hc0;
  localparam logic [15:0] TYPE_A     = 16'd1;

  localparam logic [3:0] HDR_LEN    = 4'd12;
  localparam logic [3:0] HDR_SPLIT  = 4'd8;
  localparam logic [3:0] QFIX_LEN   = 4'd4;
  localparam logic [3:0] RFIX_LEN   = 4'd10;
  localparam logic [3:0] RFIX_SPLIT = 4'd6 + 4'd2;

  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);
  localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic        no_recursion;
    logic [1:0]  section;
    logic [15:0] rr_type;
    logic [15:0] rr_class;
    logic [31:0] ttl;
    logic [15:0] rdata_len;
    logic [31:0] ipv4_addr;
    logic [63:0] header_counts;
    logic        end_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } result_pair_t;

endpackage

`default_nettype wire

@@ sv/dns_response_record_parser.sv @@
// DNS response record parser.
// Input channel: one packet byte per transaction (rx_byte, final_byte) under
// in_valid and in_stall. Output channel: one result per transaction under
// out_valid and out_stall, with every result field on a port of its own.
// Configuration: cfg_valid, cfg_ready and cfg_data write expected_id; cfg_ready
// is always high. Writes are to be made only while the block is idle; the block
// does not enforce this. Each accepted byte is parsed in the cycle it is taken;
// its results enter a four-entry result queue at that clock edge, and the first
// shows in the next cycle. One byte per cycle is taken while in_stall is low.
// A byte causes at most two results, two only when it is the final byte of a
// packet that has not finished its sections; the queue drains one result per
// cycle while out_stall is low. in_stall rises when the queue holds three or
// more results, which happens only when the receiver stalls the output channel.
// A stalled result stays on the output ports unchanged until it is taken.
// Synchronous reset clears the parse state and empties the queue; expected_id
// returns to 42. The final byte of each packet returns the parse state to its
// reset values.
`timescale 1ns / 1ps
`default_nettype none

module dns_response_record_parser
  import dnsrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [1:0]  status,
  output logic        no_recursion,
  output logic [1:0]  section,
  output logic [15:0] rr_type,
  output logic [15:0] rr_class,
  output logic [31:0] ttl,
  output logic [15:0] rdata_len,
  output logic [31:0] ipv4_addr,
  output logic [63:0] header_counts,
  output logic        end_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0]  expected_id;
  logic         in_acc;
  logic         rq_full;
  result_pair_t pair;
  result_t      head;

  assign cfg_ready = 1'b1;
  assign in_stall  = rq_full;
  assign in_acc    = in_valid && !rq_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id <= ID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      expected_id <= cfg_data;
    end
  end

  dnsrp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (in_acc),
    .rx_byte     (rx_byte),
    .final_byte  (final_byte),
    .expected_id (expected_id),
    .res         (pair)
  );

  dnsrp_rq u_rq (
    .clk       (clk),
    .rst       (rst),
    .push      (in_acc),
    .pair      (pair),
    .pop       (!out_stall),
    .head      (head),
    .not_empty (out_valid),
    .full      (rq_full)
  );

  assign kind          = head.kind;
  assign status        = head.status;
  assign no_recursion  = head.no_recursion;
  assign section       = head.section;
  assign rr_type       = head.rr_type;
  assign rr_class      = head.rr_class;
  assign ttl           = head.ttl;
  assign rdata_len     = head.rdata_len;
  assign ipv4_addr     = head.ipv4_addr;
  assign header_counts = head.header_counts;
  assign end_of_run    = head.end_of_run;

endmodule

`default_nettype wire

@@ sv/dnsrp_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dnsrp_core
  import dnsrp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   rx_byte,
  input  logic         final_byte,
  input  logic [15:0]  expected_id,
  output result_pair_t res
);

  phase_t      phase, phase_next;
  logic [3:0]  fbc, fbc_next;
  logic [63:0] hdr0, hdr0_next;
  logic [31:0] hdr1, hdr1_next;
  logic [1:0]  sec, sec_next;
  logic [15:0] entries, entries_next;
  logic [7:0]  label, label_next;
  logic [63:0] tail0, tail0_next;
  logic [15:0] tail1, tail1_next;
  logic [15:0] data_left, data_left_next;
  logic [31:0] addr, addr_next;
  logic        halted, halted_next;

  function automatic logic [15:0] count_of(input logic [63:0] h0, input logic [31:0] h1,
                                           input logic [1:0] s);
    logic [15:0] c;
    case (s)
      2'd0: c = h0[31:16];
      2'd1: c = h0[15:0];
      2'd2: c = h1[31:16];
      default: c = h1[15:0];
    endcase
    return c;
  endfunction

  always_comb begin
    logic [3:0]  fbc_inc;
    logic        main_v;
    result_t     main_r;
    result_t     trunc_r;
    logic        trunc_v;
    logic [1:0]  st;
    logic        enter_req;
    logic [2:0]  enter_start;
    logic        entry_fin;
    logic        emit_rec;
    logic [63:0] rec_t0;
    logic [15:0] rec_t1;
    logic [31:0] rec_a;
    logic [15:0] idx;
    logic [31:0] addr_new;
    logic [15:0] dl_dec;
    logic [7:0]  lbl_dec;
    logic [15:0] ent_dec;
    logic [15:0] cnt;
    logic        found;

    phase_next     = phase;
    fbc_next       = fbc;
    hdr0_next      = hdr0;
    hdr1_next      = hdr1;
    sec_next       = sec;
    entries_next   = entries;
    label_next     = label;
    tail0_next     = tail0;
    tail1_next     = tail1;
    data_left_next = data_left;
    addr_next      = addr;
    halted_next    = halted;

    fbc_inc     = fbc + 4'd1;
    main_v      = 1'b0;
    main_r      = '0;
    trunc_r     = '0;
    st          = ST_OK;
    enter_req   = 1'b0;
    enter_start = 3'd0;
    entry_fin   = 1'b0;
    emit_rec    = 1'b0;
    rec_t0      = tail0;
    rec_t1      = tail1;
    rec_a       = 32'd0;
    idx         = tail1 - data_left;
    addr_new    = addr;
    dl_dec      = data_left - 16'd1;
    lbl_dec     = label - 8'd1;
    ent_dec     = entries - 16'd1;
    cnt         = 16'd0;
    found       = 1'b0;

    if (!halted) begin
      case (phase)
        PH_HEADER: begin
          if (fbc < HDR_SPLIT) begin
            hdr0_next = {hdr0[55:0], rx_byte};
          end else begin
            hdr1_next = {hdr1[23:0], rx_byte};
          end
          fbc_next = fbc_inc;
          if (fbc_inc >= HDR_LEN) begin
            if (hdr0_next[63:48] != expected_id) begin
              st = ST_BAD_ID;
            end else if ((hdr0_next[47:40] & FLAG_MASK) == 8'd0) begin
              st = ST_NOT_ANSWER;
            end
            main_v               = 1'b1;
            main_r.kind          = KIND_HEADER;
            main_r.status        = st;
            main_r.no_recursion  = ((hdr0_next[39:32] & FLAG_MASK) == 8'd0);
            main_r.header_counts = {hdr0_next[31:0], hdr1_next};
            fbc_next             = 4'd0;
            if (st != ST_OK) begin
              halted_next = 1'b1;
            end else begin
              enter_req = 1'b1;
            end
          end
        end
        PH_NAME: begin
          if (rx_byte == 8'd0) begin
            phase_next = (sec == 2'd0) ? PH_QFIX : PH_RFIX;
            fbc_next   = 4'd0;
          end else if ((rx_byte & PTR_MASK) == PTR_MASK) begin
            phase_next = PH_PTR;
          end else begin
            label_next = rx_byte;
            phase_next = PH_LABEL;
          end
        end
        PH_LABEL: begin
          label_next = lbl_dec;
          if (lbl_dec == 8'd0) begin
            phase_next = PH_NAME;
          end
        end
        PH_PTR: begin
          phase_next = (sec == 2'd0) ? PH_QFIX : PH_RFIX;
          fbc_next   = 4'd0;
        end
        PH_QFIX: begin
          tail0_next = {32'd0, tail0[23:0], rx_byte};
          fbc_next   = fbc_inc;
          if (fbc_inc >= QFIX_LEN) begin
            main_v          = 1'b1;
            main_r.kind     = KIND_QUESTION;
            main_r.rr_type  = tail0_next[31:16];
            main_r.rr_class = tail0_next[15:0];
            entry_fin       = 1'b1;
          end
        end
        PH_RFIX: begin
          if (fbc < RFIX_SPLIT) begin
            tail0_next = {tail0[55:0], rx_byte};
          end else begin
            tail1_next = {tail1[7:0], rx_byte};
          end
          fbc_next = fbc_inc;
          if (fbc_inc >= RFIX_LEN) begin
            data_left_next = tail1_next;
            addr_next      = 32'd0;
            if (tail1_next == 16'd0) begin
              emit_rec = 1'b1;
              rec_t0   = tail0_next;
              rec_t1   = tail1_next;
              rec_a    = 32'd0;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
        default: begin
          if (idx < 16'd4) begin
            case (idx[1:0])
              2'd0: addr_new[31:24] = addr[31:24] | rx_byte;
              2'd1: addr_new[23:16] = addr[23:16] | rx_byte;
              2'd2: addr_new[15:8]  = addr[15:8] | rx_byte;
              default: addr_new[7:0] = addr[7:0] | rx_byte;
            endcase
          end
          addr_next      = addr_new;
          data_left_next = dl_dec;
          if (dl_dec == 16'd0) begin
            emit_rec = 1'b1;
            rec_t0   = tail0;
            rec_t1   = tail1;
            rec_a    = addr_new;
          end
        end
      endcase
    end

    if (emit_rec) begin
      main_v           = 1'b1;
      main_r.kind      = KIND_RECORD;
      main_r.section   = sec;
      main_r.rr_type   = rec_t0[63:48];
      main_r.rr_class  = rec_t0[47:32];
      main_r.ttl       = rec_t0[31:0];
      main_r.rdata_len = rec_t1;
      main_r.ipv4_addr = (rec_t0[63:48] == TYPE_A) ? rec_a : 32'd0;
      entry_fin        = 1'b1;
    end

    if (entry_fin) begin
      fbc_next     = 4'd0;
      addr_next    = 32'd0;
      tail0_next   = 64'd0;
      tail1_next   = 16'd0;
      entries_next = ent_dec;
      if (ent_dec == 16'd0) begin
        enter_req   = 1'b1;
        enter_start = {1'b0, sec} + 3'd1;
      end else begin
        phase_next = PH_NAME;
      end
    end

    if (enter_req) begin
      for (int s = 0; s < 4; s++) begin
        cnt = count_of(hdr0_next, hdr1_next, 2'(s));
        if (!found && (3'(s) >= enter_start) && (cnt != 16'd0)) begin
          found        = 1'b1;
          sec_next     = 2'(s);
          entries_next = cnt;
          phase_next   = PH_NAME;
          fbc_next     = 4'd0;
        end
      end
      if (!found) begin
        halted_next = 1'b1;
      end
    end

    trunc_v         = final_byte && !halted_next;
    trunc_r.kind    = KIND_TRUNC;
    trunc_r.section = sec_next;
    trunc_r.end_of_run = 1'b1;
    main_r.end_of_run  = !trunc_v;

    res.n  = {1'b0, main_v} + {1'b0, trunc_v};
    res.r0 = main_v ? main_r : trunc_r;
    res.r1 = trunc_r;

    if (final_byte) begin
      phase_next     = PH_HEADER;
      fbc_next       = 4'd0;
      hdr0_next      = 64'd0;
      hdr1_next      = 32'd0;
      sec_next       = 2'd0;
      entries_next   = 16'd0;
      label_next     = 8'd0;
      tail0_next     = 64'd0;
      tail1_next     = 16'd0;
      data_left_next = 16'd0;
      addr_next      = 32'd0;
      halted_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      fbc       <= 4'd0;
      hdr0      <= 64'd0;
      hdr1      <= 32'd0;
      sec       <= 2'd0;
      entries   <= 16'd0;
      label     <= 8'd0;
      tail0     <= 64'd0;
      tail1     <= 16'd0;
      data_left <= 16'd0;
      addr      <= 32'd0;
      halted    <= 1'b0;
    end else if (step) begin
      phase     <= phase_next;
      fbc       <= fbc_next;
      hdr0      <= hdr0_next;
      hdr1      <= hdr1_next;
      sec       <= sec_next;
      entries   <= entries_next;
      label     <= label_next;
      tail0     <= tail0_next;
      tail1     <= tail1_next;
      data_left <= data_left_next;
      addr      <= addr_next;
      halted    <= halted_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/dnsrp_rq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dnsrp_rq
  import dnsrp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  result_pair_t pair,
  input  logic         pop,
  output result_t      head,
  output logic         not_empty,
  output logic         full
);

  result_t          q [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr;
  logic [RQ_AW-1:0] rd_ptr;
  logic [RQ_CW-1:0] count;
  logic [RQ_CW-1:0] push_cnt;
  logic [RQ_CW-1:0] pop_cnt;

  assign push_cnt  = push ? RQ_CW'(pair.n) : '0;
  assign pop_cnt   = (pop && not_empty) ? RQ_CW'(1) : '0;
  assign not_empty = (count != '0);
  assign full      = (count > RQ_CW'(RQ_DEPTH - 2));
  assign head      = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && (pair.n != 2'd0)) begin
      q[wr_ptr] <= pair.r0;
    end
    if (push && (pair.n == 2'd2)) begin
      q[wr_ptr + RQ_AW'(1)] <= pair.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RQ_AW'(push_cnt);
      rd_ptr <= rd_ptr + RQ_AW'(pop_cnt);
      count  <= count + push_cnt - pop_cnt;
    end
  end

endmodule

`default_nettype wire

@@ sv/dnsrp_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dnsrp_chk
  import dnsrp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  rx_byte,
  input logic        final_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  kind,
  input logic [1:0]  status,
  input logic        no_recursion,
  input logic [1:0]  section,
  input logic [15:0] rr_type,
  input logic [15:0] rr_class,
  input logic [31:0] ttl,
  input logic [15:0] rdata_len,
  input logic [31:0] ipv4_addr,
  input logic [63:0] header_counts,
  input logic        end_of_run,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [15:0] cfg_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(rr_type)
      && $stable(end_of_run))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("result queue not empty after reset");

  a_header_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != KIND_HEADER) |->
      status == ST_OK && !no_recursion && header_counts == 64'd0)
    else $error("header fields set outside header result");

  a_question: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_QUESTION) |->
      section == 2'd0 && ttl == 32'd0 && rdata_len == 16'd0 && ipv4_addr == 32'd0)
    else $error("question result carries record fields");

  a_addr_type: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_RECORD) && (rr_type != TYPE_A) |-> ipv4_addr == 32'd0)
    else $error("address reported for a record that is not type A");

endmodule

bind dns_response_record_parser dnsrp_chk u_chk (.*);

`default_nettype wire

@@ sim/dns_response_record_parser_test.sv @@
`timescale 1ns / 1ps

module dns_response_record_parser_test;
  import dnsrp_pkg::*;

  localparam logic [1:0] SEC_QUESTION = 2'd0;
  localparam logic [15:0] TYPE_CNAME = 16'd5;
  localparam logic [15:0] TYPE_SOA = 16'd6;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic final_byte = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] kind;
  logic [1:0] status;
  logic no_recursion;
  logic [1:0] section;
  logic [15:0] rr_type;
  logic [15:0] rr_class;
  logic [31:0] ttl;
  logic [15:0] rdata_len;
  logic [31:0] ipv4_addr;
  logic [63:0] header_counts;
  logic end_of_run;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = 16'h0000;

  dns_response_record_parser i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .final_byte(final_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .status(status),
    .no_recursion(no_recursion),
    .section(section),
    .rr_type(rr_type),
    .rr_class(rr_class),
    .ttl(ttl),
    .rdata_len(rdata_len),
    .ipv4_addr(ipv4_addr),
    .header_counts(header_counts),
    .end_of_run(end_of_run),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // Parser state as the predictor tracks it.
  logic [15:0] model_id;
  phase_t walk_phase;
  logic [3:0] byte_idx;
  logic [63:0] hdr_top;
  logic [31:0] hdr_bottom;
  logic [1:0] section_now;
  logic [15:0] entries_to_go;
  logic [7:0] label_to_go;
  logic [63:0] fixed_hi;
  logic [15:0] fixed_lo;
  logic [15:0] data_to_go;
  logic [31:0] addr_bytes;
  logic parse_stopped;

  result_t pending_results[$];
  logic [7:0] pkt[$];

  int mismatches = 0;
  int results_checked = 0;
  int parsed_bytes = 0;
  int packets_sent = 0;
  int id_writes = 0;
  int in_stall_cycles = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("Run stopped at the cycle limit with %0d results outstanding.",
                 pending_results.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // The receiver stalls at random, or for a long stretch when one is requested.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  initial begin
    result_t want;
    forever begin
      @(negedge clk);
      if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_results.size() == 0) begin
          $error("Result of kind %0d arrived with no expectation waiting.", kind);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", want.kind, kind);
          check_field("status", want.status, status);
          check_field("no_recursion", want.no_recursion, no_recursion);
          check_field("section", want.section, section);
          check_field("rr_type", want.rr_type, rr_type);
          check_field("rr_class", want.rr_class, rr_class);
          check_field("ttl", want.ttl, ttl);
          check_field("rdata_len", want.rdata_len, rdata_len);
          check_field("ipv4_addr", want.ipv4_addr, ipv4_addr);
          check_field("header_counts", want.header_counts, header_counts);
          check_field("end_of_run", want.end_of_run, end_of_run);
          results_checked++;
        end
      end
    end
  end

  function automatic void clear_parse_state();
    walk_phase = PH_HEADER;
    byte_idx = '0;
    hdr_top = '0;
    hdr_bottom = '0;
    section_now = '0;
    entries_to_go = '0;
    label_to_go = '0;
    fixed_hi = '0;
    fixed_lo = '0;
    data_to_go = '0;
    addr_bytes = '0;
    parse_stopped = 1'b0;
  endfunction

  // Moves to the first section from the given one that has entries; with none
  // left the packet is complete and the rest of it is skipped.
  function automatic void open_section(input int first);
    logic [15:0] count;
    for (int s = first; s < 4; s++) begin
      case (s)
        0: count = hdr_top[31:16];
        1: count = hdr_top[15:0];
        2: count = hdr_bottom[31:16];
        default: count = hdr_bottom[15:0];
      endcase
      if (count != 0) begin
        section_now = 2'(s);
        entries_to_go = count;
        walk_phase = PH_NAME;
        byte_idx = '0;
        return;
      end
    end
    parse_stopped = 1'b1;
  endfunction

  function automatic void close_entry();
    byte_idx = '0;
    addr_bytes = '0;
    fixed_hi = '0;
    fixed_lo = '0;
    entries_to_go = entries_to_go - 16'd1;
    if (entries_to_go == 0) begin
      open_section(int'(section_now) + 1);
    end else begin
      walk_phase = PH_NAME;
    end
  endfunction

  function automatic result_t record_result();
    result_t r;
    r = '0;
    r.kind = KIND_RECORD;
    r.section = section_now;
    r.rr_type = fixed_hi[63:48];
    r.rr_class = fixed_hi[47:32];
    r.ttl = fixed_hi[31:0];
    r.rdata_len = fixed_lo;
    r.ipv4_addr = (fixed_hi[63:48] == TYPE_A) ? addr_bytes : 32'h0;
    close_entry();
    return r;
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic fin);
    result_t made[$];
    result_t r;
    logic [1:0] st;
    logic [15:0] idx;
    if (!parse_stopped) begin
      parsed_bytes++;
      case (walk_phase)
        PH_HEADER: begin
          if (byte_idx < HDR_SPLIT) begin
            hdr_top = {hdr_top[55:0], b};
          end else begin
            hdr_bottom = {hdr_bottom[23:0], b};
          end
          byte_idx++;
          if (byte_idx >= HDR_LEN) begin
            if (hdr_top[63:48] != model_id) begin
              st = ST_BAD_ID;
            end else if ((hdr_top[47:40] & FLAG_MASK) == 0) begin
              st = ST_NOT_ANSWER;
            end else begin
              st = ST_OK;
            end
            r = '0;
            r.kind = KIND_HEADER;
            r.status = st;
            r.no_recursion = ((hdr_top[39:32] & FLAG_MASK) == 0);
            r.header_counts = {hdr_top[31:0], hdr_bottom};
            made.push_back(r);
            byte_idx = '0;
            if (st != ST_OK) begin
              parse_stopped = 1'b1;
            end else begin
              open_section(0);
            end
          end
        end
        PH_NAME: begin
          if (b == 0) begin
            walk_phase = (section_now == SEC_QUESTION) ? PH_QFIX : PH_RFIX;
            byte_idx = '0;
          end else if ((b & PTR_MASK) == PTR_MASK) begin
            walk_phase = PH_PTR;
          end else begin
            label_to_go = b;
            walk_phase = PH_LABEL;
          end
        end
        PH_LABEL: begin
          label_to_go = label_to_go - 8'd1;
          if (label_to_go == 0) walk_phase = PH_NAME;
        end
        PH_PTR: begin
          walk_phase = (section_now == SEC_QUESTION) ? PH_QFIX : PH_RFIX;
          byte_idx = '0;
        end
        PH_QFIX: begin
          fixed_hi = {32'h0, fixed_hi[23:0], b};
          byte_idx++;
          if (byte_idx >= QFIX_LEN) begin
            r = '0;
            r.kind = KIND_QUESTION;
            r.section = SEC_QUESTION;
            r.rr_type = fixed_hi[31:16];
            r.rr_class = fixed_hi[15:0];
            made.push_back(r);
            close_entry();
          end
        end
        PH_RFIX: begin
          if (byte_idx < RFIX_SPLIT) begin
            fixed_hi = {fixed_hi[55:0], b};
          end else begin
            fixed_lo = {fixed_lo[7:0], b};
          end
          byte_idx++;
          if (byte_idx >= RFIX_LEN) begin
            data_to_go = fixed_lo;
            addr_bytes = '0;
            if (data_to_go == 0) begin
              made.push_back(record_result());
            end else begin
              walk_phase = PH_DATA;
            end
          end
        end
        default: begin
          idx = fixed_lo - data_to_go;
          if (idx < 4) addr_bytes = addr_bytes | (32'(b) << (8 * (3 - idx)));
          data_to_go = data_to_go - 16'd1;
          if (data_to_go == 0) made.push_back(record_result());
        end
      endcase
    end
    if (fin) begin
      if (!parse_stopped) begin
        r = '0;
        r.kind = KIND_TRUNC;
        r.section = section_now;
        made.push_back(r);
      end
      clear_parse_state();
    end
    for (int i = 0; i < made.size(); i++) begin
      r = made[i];
      r.end_of_run = (i == made.size() - 1);
      pending_results.push_back(r);
    end
  endtask

  // Called at a rising edge; returns at the edge where the byte is accepted.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    logic took;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    final_byte <= fin;
    do begin
      @(negedge clk);
      took = !in_stall;
      if (in_stall) in_stall_cycles++;
      @(posedge clk);
    end while (!took);
    predict_byte(b, fin);
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
    pkt.delete();
    packets_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_expected_id(input logic [15:0] value);
    logic took;
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    cfg_valid <= 1'b0;
    model_id = value;
    id_writes++;
  endtask

  function automatic void put16(input logic [15:0] v);
    pkt.push_back(v[15:8]);
    pkt.push_back(v[7:0]);
  endfunction

  function automatic void put_header(input logic [15:0] id, input logic [15:0] flags,
                                     input logic [15:0] qd, input logic [15:0] an,
                                     input logic [15:0] ns, input logic [15:0] ar);
    put16(id);
    put16(flags);
    put16(qd);
    put16(an);
    put16(ns);
    put16(ar);
  endfunction

  function automatic void put_name(input int labels, input bit compressed);
    int len;
    int pick;
    for (int i = 0; i < labels; i++) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        len = $urandom_range(8'h40, 8'hbf);
      end else if (pick < 10) begin
        len = $urandom_range(9, 63);
      end else begin
        len = $urandom_range(1, 8);
      end
      pkt.push_back(8'(len));
      repeat (len) pkt.push_back(8'($urandom));
    end
    if (compressed) begin
      pkt.push_back(PTR_MASK | 8'($urandom_range(0, 63)));
      pkt.push_back(8'($urandom));
    end else begin
      pkt.push_back(8'h00);
    end
  endfunction

  function automatic void put_record(input logic [15:0] rtype, input logic [15:0] rclass,
                                     input logic [31:0] life, input logic [15:0] rdlen,
                                     input int data_bytes);
    put16(rtype);
    put16(rclass);
    put16(life[31:16]);
    put16(life[15:0]);
    put16(rdlen);
    repeat (data_bytes) pkt.push_back(8'($urandom));
  endfunction

  task automatic build_random_packet();
    int pick;
    int cut;
    logic [15:0] id;
    logic [15:0] flags;
    logic [15:0] counts [4];
    logic [15:0] rtype;
    logic [15:0] rclass;
    logic [15:0] rdlen;
    pick = $urandom_range(99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom));
      return;
    end
    id = (pick < 15) ? 16'($urandom) : model_id;
    flags = 16'($urandom);
    if (pick >= 20) flags[15] = 1'b1;
    for (int s = 0; s < 4; s++) begin
      counts[s] = ($urandom_range(99) < 4) ? 16'($urandom) : 16'($urandom_range(0, 3));
    end
    put_header(id, flags, counts[0], counts[1], counts[2], counts[3]);
    for (int s = 0; s < 4; s++) begin
      for (int e = 0; e < counts[s] && e < 4; e++) begin
        put_name($urandom_range(0, 3), $urandom_range(0, 1));
        case ($urandom_range(0, 3))
          0, 1: rtype = TYPE_A;
          2: rtype = $urandom_range(0, 1) ? TYPE_CNAME : TYPE_SOA;
          default: rtype = 16'($urandom);
        endcase
        rclass = ($urandom_range(99) < 70) ? 16'd1 : 16'($urandom);
        if (s == 0) begin
          put16(rtype);
          put16(rclass);
        end else begin
          rdlen = (rtype == TYPE_A && $urandom_range(99) < 80) ? 16'd4
                                                                : 16'($urandom_range(0, 10));
          put_record(rtype, rclass, $urandom, rdlen, rdlen);
        end
      end
    end
    pick = $urandom_range(99);
    if (pick < 15) begin
      cut = $urandom_range(1, pkt.size() - 1);
      while (pkt.size() > cut) void'(pkt.pop_back());
    end else if (pick < 25) begin
      repeat ($urandom_range(1, 4)) pkt.push_back(8'($urandom));
    end
  endtask

  task automatic test_header_checks();
    put_header(16'd42, 16'h8180, 16'h0, 16'h0, 16'h0, 16'h0);
    send_packet();
    put_header(16'h002b, 16'h8180, 16'h1, 16'h0, 16'h0, 16'h0);
    pkt.push_back(8'h00);
    pkt.push_back(8'hff);
    pkt.push_back(8'h55);
    send_packet();
    put_header(16'd42, 16'h0000, 16'h0, 16'h0, 16'h0, 16'h0);
    send_packet();
    put_header(16'h0000, 16'h0000, 16'h0, 16'h0, 16'h0, 16'h0);
    send_packet();
    put_header(16'd42, 16'h8180, 16'h1, 16'h0, 16'h0, 16'h0);
    while (pkt.size() > 5) void'(pkt.pop_back());
    send_packet();
    pkt.push_back(8'hff);
    send_packet();
  endtask

  task automatic test_section_walk();
    // One packet through all four sections: long label, short address,
    // zero-length data, and bytes after the packet is already complete.
    put_header(16'd42, 16'h8500, 16'h1, 16'h3, 16'h1, 16'h1);
    pkt.push_back(8'h40);
    repeat (64) pkt.push_back(8'($urandom));
    put_name(1, 0);
    put16(TYPE_A);
    put16(16'h0001);
    put_name(0, 1);
    put_record(TYPE_A, 16'hffff, 32'hffffffff, 16'd4, 4);
    put_name(1, 0);
    put_record(TYPE_A, 16'h0001, 32'h0, 16'd2, 2);
    put_name(0, 1);
    put_record(TYPE_CNAME, 16'h0001, 32'd300, 16'd0, 0);
    put_name(0, 1);
    put_record(TYPE_SOA, 16'h0001, 32'd3600, 16'd6, 6);
    put_name(0, 0);
    put_record(16'hffff, 16'h0000, 32'h0, 16'd5, 5);
    pkt.push_back(8'hff);
    pkt.push_back(8'h00);
    send_packet();
    put_header(16'd42, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    pkt.push_back(8'hff);
    pkt.push_back(8'hff);
    pkt.push_back(8'h00);
    pkt.push_back(8'h01);
    send_packet();
    put_header(16'd42, 16'h8000, 16'h0, 16'h1, 16'h0, 16'h0);
    put_name(0, 1);
    put_record(TYPE_A, 16'h0001, 32'd5, 16'hffff, 6);
    send_packet();
  endtask

  task automatic test_expected_id_extremes();
    write_expected_id(16'hffff);
    put_header(16'hffff, 16'h8080, 16'h0, 16'h0, 16'h0, 16'h0);
    send_packet();
    put_header(16'd42, 16'h8080, 16'h0, 16'h0, 16'h0, 16'h0);
    send_packet();
    write_expected_id(16'h0000);
    put_header(16'h0000, 16'hffff, 16'h0, 16'h0, 16'h0, 16'h1);
    put_name(0, 1);
    put_record(TYPE_A, 16'h0001, 32'h0, 16'd4, 4);
    send_packet();
  endtask

  task automatic test_output_holdoff();
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 150;
    put_header(model_id, 16'h8180, 16'd20, 16'd6, 16'h0, 16'h0);
    repeat (20) begin
      put_name(0, 1);
      put16(TYPE_A);
      put16(16'h0001);
    end
    repeat (6) begin
      put_name(0, 1);
      put_record(TYPE_A, 16'h0001, $urandom, 16'd4, 4);
    end
    send_packet();
    wait_drained();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int byte_goal);
    int stop_at;
    write_expected_id(16'($urandom));
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = parsed_bytes + byte_goal;
    while (parsed_bytes < stop_at) begin
      if ($urandom_range(99) < 8) wait_drained();
      build_random_packet();
      send_packet();
    end
  endtask

  initial begin
    model_id = ID_RESET;
    clear_parse_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_header_checks();
    test_section_walk();
    test_expected_id_extremes();
    test_output_holdoff();
    test_random_traffic(0, 0, 220);
    test_random_traffic(45, 0, 220);
    test_random_traffic(0, 45, 220);
    test_random_traffic(7, 7, 220);
    wait_drained();
    repeat (10) @(posedge clk);
    $display("Checked %0d results from %0d packets, %0d parsed bytes, %0d id writes.",
             results_checked, packets_sent, parsed_bytes, id_writes);
    $display("Input was stalled for %0d cycles across hold-off and random stall phases.",
             in_stall_cycles);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/dnsrp_pkg.sv
sv/dnsrp_core.sv
sv/dnsrp_rq.sv
sv/dns_response_record_parser.sv
sv/dnsrp_chk.sv
sim/dns_response_record_parser_test.sv
